[hw/rtl/xorshift128_range_generator_core_defines.svh]
// Assertion macros for the xorshift128 range generator checker.
// Depends on nothing; expects clk, and rst_n for XRG_ASSERT_RST, in the scope of each use.
`ifndef XORSHIFT128_RANGE_GENERATOR_CORE_DEFINES_SVH
`define XORSHIFT128_RANGE_GENERATOR_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define XRG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define XRG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/xrg_pkg.sv]
// Shared types and constants for the xorshift128 range generator.
// Used by the controller, the datapath and the top level.
package xrg_pkg;

    localparam logic [31:0] SEED_X    = 32'd123456789;
    localparam logic [31:0] SEED_Y    = 32'd362436069;
    localparam logic [31:0] SEED_Z    = 32'd521288629;
    localparam logic [31:0] SEED_W    = 32'd88675123;
    localparam logic [31:0] RAW_MASK  = 32'h7fffffff;
    localparam logic [31:0] FRAC_MASK = 32'h007fffff;

    localparam int RAW_BITS = 31;
    localparam int CNT_BITS = 5;

    localparam logic [1:0] ACT_RAW   = 2'd0;
    localparam logic [1:0] ACT_RANGE = 2'd1;
    localparam logic [1:0] ACT_FRAC  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } xrg_state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic out_load;
    } xrg_cmd_t;

    typedef struct packed {
        logic needs_div;
        logic div_last;
    } xrg_status_t;

endpackage

[hw/rtl/xrg_datapath.sv]
// Datapath: generator state, span and remainder divider, result and output registers.
// Depends on xrg_pkg; driven by xrg_controller commands.
module xrg_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seed_wr_en,
    input  logic [31:0]          seed_wr_data,
    input  logic [1:0]           action,
    input  logic [31:0]          min_value,
    input  logic [31:0]          max_value,
    input  xrg_pkg::xrg_cmd_t    cmd,
    output xrg_pkg::xrg_status_t status,
    output logic [31:0]          value
);
    import xrg_pkg::*;

    logic [31:0]         x_reg, y_reg, z_reg, w_reg;
    logic [31:0]         t_val, w_new, raw_new, span, mag;
    logic                advance;
    logic [31:0]         mag_reg, mag_next;
    logic [31:0]         lo_reg, lo_next;
    logic [RAW_BITS-1:0] dvd_reg, dvd_next;
    logic [31:0]         rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [31:0]         res_reg, res_next;
    logic [31:0]         out_reg;
    logic [32:0]         rem_shift, rem_diff;
    logic [31:0]         rem_step;

    assign t_val   = x_reg ^ (x_reg << 11);
    assign w_new   = (w_reg ^ (w_reg >> 19)) ^ (t_val ^ (t_val >> 8));
    assign raw_new = w_new & RAW_MASK;
    assign span    = max_value - min_value;
    assign mag     = span[31] ? (32'd0 - span) : span;

    assign status.needs_div = (action == ACT_RANGE) && (span != 32'd0);
    assign status.div_last  = (cnt_reg == CNT_BITS'(1));

    // Range requests with an empty span and the unused action leave the state alone.
    assign advance = cmd.accept && ((action == ACT_RAW) || (action == ACT_FRAC)
                                    || status.needs_div);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= SEED_X;
            y_reg <= SEED_Y;
            z_reg <= SEED_Z;
            w_reg <= SEED_W;
        end
        else if (seed_wr_en)
        begin
            x_reg <= SEED_X;
            y_reg <= SEED_Y;
            z_reg <= SEED_Z;
            w_reg <= ((seed_wr_data == 32'd0) || seed_wr_data[31]) ? SEED_W : seed_wr_data;
        end
        else if (advance)
        begin
            x_reg <= y_reg;
            y_reg <= z_reg;
            z_reg <= w_reg;
            w_reg <= w_new;
        end
    end

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, dvd_reg[RAW_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, mag_reg};
    assign rem_step  = rem_diff[32] ? rem_shift[31:0] : rem_diff[31:0];

    always_comb
    begin
        mag_next = mag_reg;
        lo_next  = lo_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        if (cmd.accept)
        begin
            mag_next = mag;
            lo_next  = min_value;
            dvd_next = raw_new[RAW_BITS-1:0];
            rem_next = 32'd0;
            cnt_next = CNT_BITS'(RAW_BITS);
            case (action)
                ACT_RAW:  res_next = raw_new;
                ACT_FRAC: res_next = raw_new & FRAC_MASK;
                default:  res_next = 32'd0;
            endcase
        end
        else if (cmd.div_step)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = rem_step;
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (status.div_last)
            begin
                res_next = rem_step + lo_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        lo_reg  <= lo_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign value = out_reg;

endmodule

[hw/rtl/xrg_controller.sv]
// Controller: request state machine and output valid flag.
// Depends on xrg_pkg; commands xrg_datapath.
module xrg_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  xrg_pkg::xrg_status_t status,
    output xrg_pkg::xrg_cmd_t    cmd
);
    import xrg_pkg::*;

    xrg_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.needs_div ? ST_DIVIDE : ST_DONE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_DIVIDE: cmd.div_step = 1'b1;
            ST_DONE:   cmd.out_load = out_free;
            default:   in_ready = 1'b0;
        endcase
    end

    // Hold the word until taken; a new load replaces a word taken this cycle.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/xorshift128_range_generator_core.sv]
// Xorshift128 range generator, top level: stream ports and seed register port.
// Depends on xrg_pkg, xrg_controller and xrg_datapath.
// One request word in, one result word out. Raw and fraction requests, range requests
// with an empty span and requests with the unused action pass through the result
// register to the output register, which loads once it is free. Range requests first
// run the 31 steps of the radix-2 remainder divider (one dividend bit per cycle). The
// controller returns to idle as the result is loaded, so the next request can then be
// accepted. The block takes one request at a time and accepts the next one while the
// previous result still waits in the output register. A seed write reloads the generator
// state; write it only while no request is in flight.
module xorshift128_range_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] min_value, [63:32] max_value
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [31:0] value
);
    import xrg_pkg::*;

    xrg_cmd_t    cmd;
    xrg_status_t status;

    xrg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    xrg_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .action       (s_axis_tuser),
        .min_value    (s_axis_tdata[31:0]),
        .max_value    (s_axis_tdata[63:32]),
        .cmd          (cmd),
        .status       (status),
        .value        (m_axis_tdata)
    );

endmodule

[hw/rtl/xrg_checker.sv]
// Port-level checker for the xorshift128 range generator, bound to the top level.
// Depends on xorshift128_range_generator_core_defines.svh.
`include "xorshift128_range_generator_core_defines.svh"

module xrg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        seed_wr_en,
    input logic [31:0] seed_wr_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // Output word must hold while stalled.
    `XRG_ASSERT_RST(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

    // One request at a time: ready drops after an accept.
    `XRG_ASSERT_RST(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while another is in flight")

    // A fresh result appears only as the block returns to idle.
    `XRG_ASSERT_RST(a_result_idle, $rose(m_axis_tvalid) |-> s_axis_tready, "result shown while busy")

    // No output word during reset.
    `XRG_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind xorshift128_range_generator_core xrg_checker u_xrg_checker (.*);
